// ----- hdl/sca_pkg.sv -----
// Shared types, widths and pipeline stage numbers for the segment closest approach block.
// Used by sca_mul, sca_div and segment_closest_approach; depends on nothing else.
`default_nettype none

package sca_pkg;

  // Fixed point formats
  localparam int unsigned CW              = 32;             // coordinate width, Q16.16
  localparam int unsigned VW              = CW + 1;         // endpoint difference width
  localparam int unsigned PARAM_FRAC_BITS = 32;             // fraction bits of sc and tc
  localparam int unsigned SCW             = PARAM_FRAC_BITS + 1;
  localparam int unsigned PPW             = 2 * VW;         // one coordinate product
  localparam int unsigned DOTW            = PPW + 2;        // dot product of two differences
  localparam int unsigned NW              = 2 * DOTW;       // determinant and numerators
  localparam int unsigned RW              = NW + 1;         // divider partial remainder
  localparam int unsigned OPW             = VW + SCW + 1;   // difference times parameter
  localparam int unsigned ACCW            = OPW + 1;        // output accumulator
  localparam int unsigned HIW             = ACCW - PARAM_FRAC_BITS;
  localparam int unsigned LIMW            = 16;

  // Wide multiplier split into three chunks per operand
  localparam int unsigned CHUNK = (DOTW + 2) / 3;
  localparam int unsigned MAGW  = 3 * CHUNK;
  localparam int unsigned ROWW  = 4 * CHUNK + 2;
  localparam int unsigned TOTW  = ROWW + 2 * CHUNK + 2;

  // Register stage at which each quantity is held
  localparam int unsigned MUL_LAT   = 5;
  localparam int unsigned DIV_LAT   = PARAM_FRAC_BITS + 2;
  localparam int unsigned STG_DOT   = 3;
  localparam int unsigned STG_PROD  = STG_DOT + MUL_LAT;
  localparam int unsigned STG_CLAMP = STG_PROD + 3;
  localparam int unsigned STG_PARAM = STG_CLAMP + DIV_LAT;
  localparam int unsigned STG_OUT   = STG_PARAM + 3;

  localparam logic [LIMW-1:0] LIMIT_RESET = LIMW'(1);

  typedef struct packed {
    logic signed [CW-1:0] a_start_x;
    logic signed [CW-1:0] a_start_y;
    logic signed [CW-1:0] a_start_z;
    logic signed [CW-1:0] a_end_x;
    logic signed [CW-1:0] a_end_y;
    logic signed [CW-1:0] a_end_z;
    logic signed [CW-1:0] b_start_x;
    logic signed [CW-1:0] b_start_y;
    logic signed [CW-1:0] b_start_z;
    logic signed [CW-1:0] b_end_x;
    logic signed [CW-1:0] b_end_y;
    logic signed [CW-1:0] b_end_z;
  } seg_pair_t;

  typedef struct packed {
    logic signed [CW-1:0] gap_x;
    logic signed [CW-1:0] gap_y;
    logic signed [CW-1:0] gap_z;
  } gap_t;

  // Direction and offset vectors, one difference per axis
  typedef struct packed {
    logic [2:0][VW-1:0] u;
    logic [2:0][VW-1:0] v;
    logic [2:0][VW-1:0] w;
  } diff_t;

  typedef struct packed {
    logic signed [DOTW-1:0] a;
    logic signed [DOTW-1:0] b;
    logic signed [DOTW-1:0] c;
    logic signed [DOTW-1:0] d;
    logic signed [DOTW-1:0] e;
  } dots_t;

endpackage

`default_nettype wire

// ----- hdl/sca_mul.sv -----
// Pipelined signed multiplier for dot-product values, five register stages.
// Depends on sca_pkg for the operand widths and chunk split.
`default_nettype none

module sca_mul
  import sca_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic signed [DOTW-1:0] a_i,
  input  wire logic signed [DOTW-1:0] b_i,
  output logic signed [NW-1:0]    p_o
);

  logic [DOTW-1:0]       ma_d, mb_d;
  logic [MAGW-1:0]       ma_q, mb_q;
  logic [4:1]            sgn_q;
  logic [2*CHUNK-1:0]    pp_q [3][3];
  logic [ROWW-1:0]       row_q [3];
  logic [NW-1:0]         tot_q;
  logic signed [NW-1:0]  p_q;
  logic [TOTW-1:0]       tot_d;

  // Magnitudes and result sign.
  always_comb begin
    ma_d = a_i[DOTW-1] ? DOTW'(-a_i) : a_i;
    mb_d = b_i[DOTW-1] ? DOTW'(-b_i) : b_i;
  end

  always_ff @(posedge clk_i) begin
    ma_q     <= MAGW'(ma_d);
    mb_q     <= MAGW'(mb_d);
    sgn_q[1] <= a_i[DOTW-1] ^ b_i[DOTW-1];
    sgn_q[4:2] <= sgn_q[3:1];
  end

  // Partial products of chunk pairs.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pp_q[i][j] <= ma_q[i*CHUNK +: CHUNK] * mb_q[j*CHUNK +: CHUNK];
      end
    end
  end

  // One row per chunk of the first operand.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      row_q[i] <= ROWW'(pp_q[i][0]) + (ROWW'(pp_q[i][1]) << CHUNK)
                + (ROWW'(pp_q[i][2]) << (2 * CHUNK));
    end
  end

  // Rows combined into the magnitude, which always fits NW bits.
  assign tot_d = TOTW'(row_q[0]) + (TOTW'(row_q[1]) << CHUNK)
               + (TOTW'(row_q[2]) << (2 * CHUNK));

  always_ff @(posedge clk_i) begin
    tot_q <= tot_d[NW-1:0];
  end

  // Sign applied last.
  always_ff @(posedge clk_i) begin
    p_q <= sgn_q[4] ? -$signed(tot_q) : $signed(tot_q);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ----- hdl/sca_div.sv -----
// Pipelined restoring divider giving a clamped segment parameter, one quotient bit a stage.
// Depends on sca_pkg for numerator width and parameter fraction bits.
`default_nettype none

module sca_div
  import sca_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic signed [NW-1:0] num_i,
  input  wire logic signed [NW-1:0] den_i,
  output logic [SCW-1:0]          q_o
);

  logic [RW-1:0]              r_q    [PARAM_FRAC_BITS+1];
  logic [RW-1:0]              den_q  [PARAM_FRAC_BITS+1];
  logic [PARAM_FRAC_BITS-1:0] quo_q  [PARAM_FRAC_BITS+1];
  logic [PARAM_FRAC_BITS:0]   zero_q;
  logic [PARAM_FRAC_BITS:0]   one_q;
  logic [SCW-1:0]             q_q;

  // Entry stage: a nonpositive operand gives zero, a numerator at or above the
  // denominator gives exactly one; otherwise the remainder starts at the numerator.
  always_ff @(posedge clk_i) begin
    zero_q[0] <= num_i[NW-1] | ~|num_i | den_i[NW-1] | ~|den_i;
    one_q[0]  <= (num_i >= den_i);
    r_q[0]    <= RW'(num_i[NW-1:0]);
    den_q[0]  <= RW'(den_i[NW-1:0]);
    quo_q[0]  <= '0;
  end

  // One trial subtraction per stage.
  for (genvar k = 1; k <= PARAM_FRAC_BITS; k++) begin : g_step
    logic [RW-1:0] shl;
    logic [RW:0]   diff;
    logic          bit_d;

    always_comb begin
      shl   = {r_q[k-1][RW-2:0], 1'b0};
      diff  = {1'b0, shl} - {1'b0, den_q[k-1]};
      bit_d = ~diff[RW];
    end

    always_ff @(posedge clk_i) begin
      r_q[k]    <= bit_d ? diff[RW-1:0] : shl;
      den_q[k]  <= den_q[k-1];
      quo_q[k]  <= {quo_q[k-1][PARAM_FRAC_BITS-2:0], bit_d};
      zero_q[k] <= zero_q[k-1];
      one_q[k]  <= one_q[k-1];
    end
  end

  // Final selection of the parameter.
  always_ff @(posedge clk_i) begin
    if (zero_q[PARAM_FRAC_BITS]) begin
      q_q <= '0;
    end else if (one_q[PARAM_FRAC_BITS]) begin
      q_q <= {1'b1, {PARAM_FRAC_BITS{1'b0}}};
    end else begin
      q_q <= {1'b0, quo_q[PARAM_FRAC_BITS]};
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

// ----- hdl/segment_closest_approach.sv -----
// Top level of the segment closest approach block: dot products, clamping and output.
// Depends on sca_pkg, sca_mul and sca_div.
//
// Takes one segment pair word in every clock cycle and returns one gap word per pair,
// in the order of arrival. busy_o stays low: the datapath is a free-running pipeline
// of 48 register stages, of which the two restoring dividers for the segment
// parameters set most of the latency. The receiver cannot stall, and none is needed:
// done_o marks each gap word for one cycle. Write parallel_limit through cfg_we_i
// while no pair is in flight.
`default_nettype none

module segment_closest_approach
  import sca_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire seg_pair_t       in_i,
  output logic                 done_o,
  output gap_t                 res_o,
  input  wire logic            cfg_we_i,
  input  wire logic [LIMW-1:0] cfg_wdata_i
);

  logic [LIMW-1:0]       lim_q;
  logic [STG_OUT:1]      vld_q;
  logic signed [CW-1:0]  as_c [3], ae_c [3], bs_c [3], be_c [3];
  diff_t                 diff_q [STG_PARAM:1];
  logic signed [PPW-1:0] uu_q [3], uv_q [3], vv_q [3], uw_q [3], vw_q [3];
  dots_t                 dots_q [STG_PROD:STG_DOT];
  logic signed [NW-1:0]  ac_p, bb_p, be_p, cd_p, ae_p, bd_p;

  logic signed [NW-1:0]  det_q, sn9_q, tn9_q, a9_q, c9_q, e9_q, epb9_q, nd9_q, bmd9_q;
  logic signed [NW-1:0]  sn10_q, sd10_q, tn10_q, td10_q, a10_q, nd10_q, bmd10_q;
  logic signed [NW-1:0]  sn10_d, sd10_d, tn10_d, td10_d;
  logic signed [NW-1:0]  sn11_q, sd11_q, tn11_q, td11_q;
  logic signed [NW-1:0]  sn11_d, sd11_d, tn11_d, td11_d;
  logic [SCW-1:0]        sc_p, tc_p;

  logic signed [OPW-1:0]  pu_q [3], pv_q [3];
  logic signed [VW-1:0]   w46_q [3];
  logic signed [ACCW-1:0] acc_q [3];
  logic signed [CW-1:0]   gap_d [3];
  gap_t                   res_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      lim_q <= cfg_wdata_i;
    end
  end

  // Valid bits travel alongside the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[STG_OUT-1:1], start_i};
    end
  end

  assign busy_o = 1'b0;
  assign done_o = vld_q[STG_OUT];

  // Endpoints per axis.
  always_comb begin
    as_c[0] = in_i.a_start_x; as_c[1] = in_i.a_start_y; as_c[2] = in_i.a_start_z;
    ae_c[0] = in_i.a_end_x;   ae_c[1] = in_i.a_end_y;   ae_c[2] = in_i.a_end_z;
    bs_c[0] = in_i.b_start_x; bs_c[1] = in_i.b_start_y; bs_c[2] = in_i.b_start_z;
    be_c[0] = in_i.b_end_x;   be_c[1] = in_i.b_end_y;   be_c[2] = in_i.b_end_z;
  end

  // Stage 1: direction vectors u, v and offset w, then a delay line to the offset stage.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      diff_q[1].u[k] <= VW'(ae_c[k]) - VW'(as_c[k]);
      diff_q[1].v[k] <= VW'(be_c[k]) - VW'(bs_c[k]);
      diff_q[1].w[k] <= VW'(as_c[k]) - VW'(bs_c[k]);
    end
    for (int s = 2; s <= STG_PARAM; s++) begin
      diff_q[s] <= diff_q[s-1];
    end
  end

  // Stage 2: coordinate products.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      uu_q[k] <= $signed(diff_q[1].u[k]) * $signed(diff_q[1].u[k]);
      uv_q[k] <= $signed(diff_q[1].u[k]) * $signed(diff_q[1].v[k]);
      vv_q[k] <= $signed(diff_q[1].v[k]) * $signed(diff_q[1].v[k]);
      uw_q[k] <= $signed(diff_q[1].u[k]) * $signed(diff_q[1].w[k]);
      vw_q[k] <= $signed(diff_q[1].v[k]) * $signed(diff_q[1].w[k]);
    end
  end

  // Stage 3: dot products, then held while the wide products are formed.
  always_ff @(posedge clk_i) begin
    dots_q[STG_DOT].a <= DOTW'(uu_q[0]) + DOTW'(uu_q[1]) + DOTW'(uu_q[2]);
    dots_q[STG_DOT].b <= DOTW'(uv_q[0]) + DOTW'(uv_q[1]) + DOTW'(uv_q[2]);
    dots_q[STG_DOT].c <= DOTW'(vv_q[0]) + DOTW'(vv_q[1]) + DOTW'(vv_q[2]);
    dots_q[STG_DOT].d <= DOTW'(uw_q[0]) + DOTW'(uw_q[1]) + DOTW'(uw_q[2]);
    dots_q[STG_DOT].e <= DOTW'(vw_q[0]) + DOTW'(vw_q[1]) + DOTW'(vw_q[2]);
    for (int s = STG_DOT + 1; s <= STG_PROD; s++) begin
      dots_q[s] <= dots_q[s-1];
    end
  end

  // Wide products for the determinant and the numerators.
  sca_mul u_mul_ac (.clk_i(clk_i), .a_i(dots_q[STG_DOT].a), .b_i(dots_q[STG_DOT].c), .p_o(ac_p));
  sca_mul u_mul_bb (.clk_i(clk_i), .a_i(dots_q[STG_DOT].b), .b_i(dots_q[STG_DOT].b), .p_o(bb_p));
  sca_mul u_mul_be (.clk_i(clk_i), .a_i(dots_q[STG_DOT].b), .b_i(dots_q[STG_DOT].e), .p_o(be_p));
  sca_mul u_mul_cd (.clk_i(clk_i), .a_i(dots_q[STG_DOT].c), .b_i(dots_q[STG_DOT].d), .p_o(cd_p));
  sca_mul u_mul_ae (.clk_i(clk_i), .a_i(dots_q[STG_DOT].a), .b_i(dots_q[STG_DOT].e), .p_o(ae_p));
  sca_mul u_mul_bd (.clk_i(clk_i), .a_i(dots_q[STG_DOT].b), .b_i(dots_q[STG_DOT].d), .p_o(bd_p));

  // Determinant, unclamped numerators and the sums the clamps need.
  always_ff @(posedge clk_i) begin
    det_q  <= ac_p - bb_p;
    sn9_q  <= be_p - cd_p;
    tn9_q  <= ae_p - bd_p;
    a9_q   <= NW'(dots_q[STG_PROD].a);
    c9_q   <= NW'(dots_q[STG_PROD].c);
    e9_q   <= NW'(dots_q[STG_PROD].e);
    epb9_q <= NW'(dots_q[STG_PROD].e) + NW'(dots_q[STG_PROD].b);
    nd9_q  <= -NW'(dots_q[STG_PROD].d);
    bmd9_q <= NW'(dots_q[STG_PROD].b) - NW'(dots_q[STG_PROD].d);
  end

  // Parallel test and clamp of the parameter on A.
  always_comb begin
    if (det_q < $signed(NW'(lim_q))) begin
      sn10_d = '0;
      sd10_d = NW'(1);
      tn10_d = e9_q;
      td10_d = c9_q;
    end else if (sn9_q[NW-1]) begin
      sn10_d = '0;
      sd10_d = det_q;
      tn10_d = e9_q;
      td10_d = c9_q;
    end else if (sn9_q > det_q) begin
      sn10_d = det_q;
      sd10_d = det_q;
      tn10_d = epb9_q;
      td10_d = c9_q;
    end else begin
      sn10_d = sn9_q;
      sd10_d = det_q;
      tn10_d = tn9_q;
      td10_d = det_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sn10_q  <= sn10_d;
    sd10_q  <= sd10_d;
    tn10_q  <= tn10_d;
    td10_q  <= td10_d;
    a10_q   <= a9_q;
    nd10_q  <= nd9_q;
    bmd10_q <= bmd9_q;
  end

  // Clamp of the parameter on B, which may move the one on A back to an edge.
  always_comb begin
    logic tneg, tgt;
    logic signed [NW-1:0] m;
    tneg   = tn10_q[NW-1];
    tgt    = tn10_q > td10_q;
    m      = tneg ? nd10_q : bmd10_q;
    sn11_d = sn10_q;
    sd11_d = sd10_q;
    tn11_d = tneg ? '0 : (tgt ? td10_q : tn10_q);
    td11_d = td10_q;
    if (tneg || tgt) begin
      if (m[NW-1]) begin
        sn11_d = '0;
      end else if (m > a10_q) begin
        sn11_d = sd10_q;
      end else begin
        sn11_d = m;
        sd11_d = a10_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sn11_q <= sn11_d;
    sd11_q <= sd11_d;
    tn11_q <= tn11_d;
    td11_q <= td11_d;
  end

  // Segment parameters.
  sca_div u_div_s (.clk_i(clk_i), .num_i(sn11_q), .den_i(sd11_q), .q_o(sc_p));
  sca_div u_div_t (.clk_i(clk_i), .num_i(tn11_q), .den_i(td11_q), .q_o(tc_p));

  // Offsets along each segment.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      pu_q[k]  <= OPW'($signed(diff_q[STG_PARAM].u[k]) * $signed({1'b0, sc_p}));
      pv_q[k]  <= OPW'($signed(diff_q[STG_PARAM].v[k]) * $signed({1'b0, tc_p}));
      w46_q[k] <= $signed(diff_q[STG_PARAM].w[k]);
    end
  end

  // Gap vector at full precision.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      acc_q[k] <= (ACCW'(w46_q[k]) <<< PARAM_FRAC_BITS) + ACCW'(pu_q[k]) - ACCW'(pv_q[k]);
    end
  end

  // Floor to Q16.16 and saturate.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [HIW-1:0] hi;
      hi = acc_q[k][ACCW-1:PARAM_FRAC_BITS];
      if ((&hi[HIW-1:CW-1]) || !(|hi[HIW-1:CW-1])) begin
        gap_d[k] = $signed(hi[CW-1:0]);
      end else if (hi[HIW-1]) begin
        gap_d[k] = $signed({1'b1, {(CW-1){1'b0}}});
      end else begin
        gap_d[k] = $signed({1'b0, {(CW-1){1'b1}}});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.gap_x <= gap_d[0];
    res_q.gap_y <= gap_d[1];
    res_q.gap_z <= gap_d[2];
  end

  assign res_o = res_q;

endmodule

`default_nettype wire
